### hw/rtl/assert_macros.svh
// Assertion macros shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/jts_pkg.sv
// Shared types, codes, character constants and literal tables of the JSON token scanner.
`timescale 1ns / 1ps

package jts_pkg;

    localparam int SPAN_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] KIND_INT    = 4'd0;
    localparam logic [3:0] KIND_DOUBLE = 4'd1;
    localparam logic [3:0] KIND_STRING = 4'd2;
    localparam logic [3:0] KIND_TRUE   = 4'd3;
    localparam logic [3:0] KIND_END    = 4'd6;
    localparam logic [3:0] KIND_LBRACE = 4'd7;
    localparam logic [3:0] KIND_RBRACE = 4'd8;
    localparam logic [3:0] KIND_LBRACK = 4'd9;
    localparam logic [3:0] KIND_RBRACK = 4'd10;
    localparam logic [3:0] KIND_COLON  = 4'd11;
    localparam logic [3:0] KIND_COMMA  = 4'd12;
    localparam logic [3:0] KIND_ERROR  = 4'd13;

    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR      = 3'd1;
    localparam logic [2:0] ERR_BAD_LITERAL   = 3'd2;
    localparam logic [2:0] ERR_UNTERMINATED  = 3'd3;
    localparam logic [2:0] ERR_TOO_LONG      = 3'd4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // One queue entry holds every token caused by one byte.
    typedef struct packed {
        logic                 two_tok;
        logic [3:0]           t0_kind;
        logic [31:0]          t0_ival;
        logic [SPAN_BITS-1:0] t0_start;
        logic [SPAN_BITS-1:0] t0_end;
        logic [2:0]           t0_err;
        logic [3:0]           t1_kind;
        logic [2:0]           t1_err;
    } jts_rec_t;

    // Number of bytes that follow the first letter of true, false and null.
    function automatic logic [2:0] lit_len(input logic [1:0] which);
        logic [2:0] len;
        unique case (which)
            2'd0:    len = 3'd3;
            2'd1:    len = 3'd4;
            2'd2:    len = 3'd3;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [1:0] idx);
        logic [7:0] ch;
        ch = CH_NUL;
        unique case (which)
            2'd0:
            begin
                unique case (idx)
                    2'd0:    ch = CH_R;
                    2'd1:    ch = CH_U;
                    2'd2:    ch = CH_E_LO;
                    default: ch = CH_NUL;
                endcase
            end
            2'd1:
            begin
                unique case (idx)
                    2'd0:    ch = CH_A;
                    2'd1:    ch = CH_L;
                    2'd2:    ch = CH_S;
                    default: ch = CH_E_LO;
                endcase
            end
            2'd2:
            begin
                unique case (idx)
                    2'd0:    ch = CH_U;
                    2'd1:    ch = CH_L;
                    2'd2:    ch = CH_L;
                    default: ch = CH_NUL;
                endcase
            end
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

### hw/rtl/jts_fifo.sv
// Short queue of token entries between the scanner front and the output back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jts_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  jts_pkg::jts_rec_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output jts_pkg::jts_rec_t rd_data,
    output logic              empty
);
    import jts_pkg::*;

    localparam logic [QUEUE_AW:0] FULL_COUNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    jts_rec_t            mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_wr;
    logic                do_rd;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_COUNT, "queue count beyond depth")
    `ASSERT_IMPLIES(a_no_overrun, wr_en, !full, "entry written into a full queue")

endmodule

### hw/rtl/jts_front.sv
// Scanner front: accepts document bytes, tracks the scan state and builds token entries.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jts_front #(
    parameter int POS_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        byte_in,
    input  logic              in_push,
    input  logic              q_full,
    output jts_pkg::jts_rec_t q_rec,
    output logic              q_push
);
    import jts_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_STR,
        MODE_LIT,
        MODE_SKIP
    } mode_t;

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    mode_t               mode_reg, mode_next;
    logic [1:0]          which_reg, which_next;
    logic [2:0]          index_reg, index_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] begin_reg, begin_next;
    logic [31:0]         mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic                stop_reg, stop_next;
    logic                frac_reg, frac_next;

    logic                accept;
    logic                clear;
    logic                idle_go;
    logic                is_digit;
    logic [POS_BITS-1:0] pos_inc;
    logic [POS_BITS-1:0] pos_last;
    logic [35:0]         mag10;
    logic [2:0]          index_inc;
    logic [2:0]          cur_len;

    logic                a_valid;
    logic [3:0]          a_kind;
    logic [31:0]         a_ival;
    logic [POS_BITS-1:0] a_start;
    logic [POS_BITS-1:0] a_end;
    logic [2:0]          a_err;
    logic                b_valid;
    logic [3:0]          b_kind;
    logic [2:0]          b_err;

    assign accept    = in_push && !q_full;
    assign is_digit  = (byte_in >= CH_0) && (byte_in <= CH_9);
    assign pos_inc   = pos_reg + 1'b1;
    assign pos_last  = pos_reg - 1'b1;
    assign mag10     = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1)
                     + {32'b0, byte_in[3:0]};
    assign index_inc = index_reg + 1'b1;
    assign cur_len   = lit_len(which_reg);

    always_comb
    begin
        mode_next  = mode_reg;
        which_next = which_reg;
        index_next = index_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        stop_next  = stop_reg;
        frac_next  = frac_reg;
        clear      = 1'b0;
        idle_go    = 1'b0;
        a_valid    = 1'b0;
        a_kind     = KIND_INT;
        a_ival     = '0;
        a_start    = '0;
        a_end      = '0;
        a_err      = ERR_NONE;
        b_valid    = 1'b0;
        b_kind     = KIND_INT;
        b_err      = ERR_NONE;

        if (mode_reg == MODE_SKIP)
        begin
            clear = (byte_in == CH_NUL);
        end
        else if ((byte_in != CH_NUL) && (pos_reg == POS_MAX))
        begin
            a_valid   = 1'b1;
            a_kind    = KIND_ERROR;
            a_err     = ERR_TOO_LONG;
            mode_next = MODE_SKIP;
        end
        else
        begin
            unique case (mode_reg)
                MODE_NUM:
                begin
                    if (is_digit)
                    begin
                        if (!stop_reg)
                        begin
                            mag_next = (mag10 > 36'h080000000) ? 32'h80000000 : mag10[31:0];
                        end
                        pos_next = pos_inc;
                    end
                    else if ((byte_in == CH_MINUS) || (byte_in == CH_PLUS))
                    begin
                        stop_next = 1'b1;
                        pos_next  = pos_inc;
                    end
                    else if ((byte_in == CH_E_LO) || (byte_in == CH_E_UP) ||
                             (byte_in == CH_DOT))
                    begin
                        stop_next = 1'b1;
                        frac_next = 1'b1;
                        pos_next  = pos_inc;
                    end
                    else
                    begin
                        a_valid = 1'b1;
                        a_start = begin_reg;
                        a_end   = pos_last;
                        if (frac_reg)
                        begin
                            a_kind = KIND_DOUBLE;
                        end
                        else
                        begin
                            a_kind = KIND_INT;
                            if (neg_reg)
                            begin
                                a_ival = 32'd0 - mag_reg;
                            end
                            else
                            begin
                                a_ival = mag_reg[31] ? 32'h7FFFFFFF : mag_reg;
                            end
                        end
                        idle_go = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    if (byte_in == CH_QUOTE)
                    begin
                        a_valid   = 1'b1;
                        a_kind    = KIND_STRING;
                        a_start   = begin_reg;
                        a_end     = pos_last;
                        mode_next = MODE_IDLE;
                        pos_next  = pos_inc;
                    end
                    else if (byte_in == CH_NUL)
                    begin
                        a_valid = 1'b1;
                        a_kind  = KIND_ERROR;
                        a_err   = ERR_UNTERMINATED;
                        clear   = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                    end
                end
                MODE_LIT:
                begin
                    if ((index_reg < cur_len) &&
                        (byte_in == lit_char(which_reg, index_reg[1:0])))
                    begin
                        pos_next = pos_inc;
                        if (index_inc == cur_len)
                        begin
                            a_valid    = 1'b1;
                            a_kind     = KIND_TRUE + {2'b0, which_reg};
                            mode_next  = MODE_IDLE;
                            index_next = '0;
                        end
                        else
                        begin
                            index_next = index_inc;
                        end
                    end
                    else
                    begin
                        a_valid = 1'b1;
                        a_kind  = KIND_ERROR;
                        a_err   = ERR_BAD_LITERAL;
                        if (byte_in == CH_NUL)
                        begin
                            clear = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_SKIP;
                        end
                    end
                end
                default:
                begin
                    idle_go = 1'b1;
                end
            endcase
        end

        if (idle_go)
        begin
            mode_next = MODE_IDLE;
            unique case (byte_in)
                CH_SPACE, CH_TAB, CH_LF:
                begin
                    pos_next = pos_inc;
                end
                CH_QUOTE:
                begin
                    mode_next  = MODE_STR;
                    begin_next = pos_inc;
                    pos_next   = pos_inc;
                end
                CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COLON, CH_COMMA:
                begin
                    b_valid  = 1'b1;
                    pos_next = pos_inc;
                    unique case (byte_in)
                        CH_LBRACE: b_kind = KIND_LBRACE;
                        CH_RBRACE: b_kind = KIND_RBRACE;
                        CH_LBRACK: b_kind = KIND_LBRACK;
                        CH_RBRACK: b_kind = KIND_RBRACK;
                        CH_COLON:  b_kind = KIND_COLON;
                        default:   b_kind = KIND_COMMA;
                    endcase
                end
                CH_T, CH_F, CH_N:
                begin
                    mode_next  = MODE_LIT;
                    which_next = (byte_in == CH_T) ? 2'd0 : (byte_in == CH_F) ? 2'd1 : 2'd2;
                    index_next = '0;
                    pos_next   = pos_inc;
                end
                CH_NUL:
                begin
                    b_valid = 1'b1;
                    b_kind  = KIND_END;
                    clear   = 1'b1;
                end
                default:
                begin
                    if (is_digit || (byte_in == CH_MINUS))
                    begin
                        mode_next  = MODE_NUM;
                        begin_next = pos_reg;
                        neg_next   = (byte_in == CH_MINUS);
                        mag_next   = is_digit ? {28'b0, byte_in[3:0]} : 32'd0;
                        stop_next  = 1'b0;
                        frac_next  = 1'b0;
                        pos_next   = pos_inc;
                    end
                    else
                    begin
                        b_valid   = 1'b1;
                        b_kind    = KIND_ERROR;
                        b_err     = ERR_BAD_CHAR;
                        mode_next = MODE_SKIP;
                    end
                end
            endcase
        end

        if (clear)
        begin
            mode_next  = MODE_IDLE;
            which_next = '0;
            index_next = '0;
            pos_next   = '0;
            begin_next = '0;
            mag_next   = '0;
            neg_next   = 1'b0;
            stop_next  = 1'b0;
            frac_next  = 1'b0;
        end
    end

    always_comb
    begin
        q_rec = '0;
        if (a_valid)
        begin
            q_rec.two_tok  = b_valid;
            q_rec.t0_kind  = a_kind;
            q_rec.t0_ival  = a_ival;
            q_rec.t0_start = SPAN_BITS'(a_start);
            q_rec.t0_end   = SPAN_BITS'(a_end);
            q_rec.t0_err   = a_err;
            q_rec.t1_kind  = b_kind;
            q_rec.t1_err   = b_err;
        end
        else
        begin
            q_rec.t0_kind = b_kind;
            q_rec.t0_err  = b_err;
        end
    end

    assign q_push = accept && (a_valid || b_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            which_reg <= '0;
            index_reg <= '0;
            pos_reg   <= '0;
            begin_reg <= '0;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            stop_reg  <= 1'b0;
            frac_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            which_reg <= which_next;
            index_reg <= index_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            stop_reg  <= stop_next;
            frac_reg  <= frac_next;
        end
    end

    `ASSERT_IMPLIES(a_skip_silent, accept && (mode_reg == MODE_SKIP), !q_push,
                    "token produced while skipping to the end of the document")
    `ASSERT_ALWAYS(a_lit_index, index_reg < 3'd4, "literal index out of range")

endmodule

### hw/rtl/jts_back.sv
// Output back: hands out the tokens of each queue entry one item at a time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jts_back (
    input  logic               clk,
    input  logic               rst_n,
    input  jts_pkg::jts_rec_t  q_head,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic [3:0]         token_kind,
    output logic signed [31:0] int_value,
    output logic [15:0]        span_start,
    output logic [15:0]        span_end,
    output logic [2:0]         error_code,
    output logic               last_of_run
);
    import jts_pkg::*;

    logic sel_reg;
    logic sel_next;
    logic take;

    assign empty       = q_empty;
    assign take        = pop && !q_empty;
    assign q_pop       = take && (sel_reg || !q_head.two_tok);
    assign sel_next    = take ? (!sel_reg && q_head.two_tok) : sel_reg;

    assign token_kind  = sel_reg ? q_head.t1_kind : q_head.t0_kind;
    assign int_value   = sel_reg ? 32'sd0 : $signed(q_head.t0_ival);
    assign span_start  = sel_reg ? '0 : q_head.t0_start;
    assign span_end    = sel_reg ? '0 : q_head.t0_end;
    assign error_code  = sel_reg ? q_head.t1_err : q_head.t0_err;
    assign last_of_run = sel_reg || !q_head.two_tok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

    `ASSERT_IMPLIES(a_sel_pair, sel_reg, !q_empty && q_head.two_tok,
                    "second token selected without a two-token entry")
    `ASSERT_NEXT(a_pair_split, take && !sel_reg && q_head.two_tok, sel_reg,
                 "second token of an entry was skipped")

endmodule

### hw/rtl/json_token_scanner.sv
// Byte-serial JSON tokenizer: top level joining the scanner front, token queue and output back.
// Accepts one byte per clock unless full; a byte's tokens are registered as one queue entry.
// A byte yields at most two tokens, read from a four-entry queue one per cycle while pop is high.
// Input stalls (full high) only while that queue is full, e.g. under repeated two-token bytes.
// Asynchronous active-low reset returns the scanner to idle at offset zero and empties the queue.
`timescale 1ns / 1ps

module json_token_scanner #(
    parameter int POS_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         byte_in,
    output logic               empty,
    input  logic               pop,
    output logic [3:0]         token_kind,
    output logic signed [31:0] int_value,
    output logic [15:0]        span_start,
    output logic [15:0]        span_end,
    output logic [2:0]         error_code,
    output logic               last_of_run
);
    import jts_pkg::*;

    jts_rec_t wr_rec;
    jts_rec_t head_rec;
    logic     wr_en;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;

    assign full = q_full;

    jts_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .in_push (push),
        .q_full  (q_full),
        .q_rec   (wr_rec),
        .q_push  (wr_en)
    );

    jts_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_rec),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (head_rec),
        .empty   (q_empty)
    );

    jts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_head      (head_rec),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .token_kind  (token_kind),
        .int_value   (int_value),
        .span_start  (span_start),
        .span_end    (span_end),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

endmodule

### tb/tb_json_token_scanner.sv
// Self-checking testbench that streams JSON documents into the token scanner and checks every token.
`timescale 1ns / 1ps

module tb_json_token_scanner;
    import jts_pkg::*;

    localparam logic [15:0] POS_LIMIT   = 16'hFFFF;
    localparam int RANDOM_BYTES         = 850;
    localparam int CALM_TAIL            = 150;
    localparam int DRAIN_CYCLES         = 16;
    localparam int SHOWN_MISMATCHES     = 100;
    localparam int CYCLE_LIMIT          = (RANDOM_BYTES + 200) * 45 * 4;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NUMBER,
        SCAN_STRING,
        SCAN_LITERAL,
        SCAN_SKIP
    } scan_mode_e;

    typedef struct {
        logic [3:0]         kind;
        logic signed [31:0] value;
        logic [15:0]        span_lo;
        logic [15:0]        span_hi;
        logic [2:0]         err;
        logic               last_of_run;
    } token_t;

    class token_checker;
        token_t      tokens_due[$];
        token_t      from_byte[$];
        int          mismatches;
        int          checked;
        string       word_tail[3];
        scan_mode_e  mode;
        logic [1:0]  lit_which;
        logic [2:0]  lit_index;
        logic [15:0] position;
        logic [15:0] token_start;
        logic [31:0] magnitude;
        logic        negative;
        logic        digits_stopped;
        logic        fraction_seen;

        function new();
            word_tail = '{"rue", "alse", "ull"};
            mismatches = 0;
            checked = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode = SCAN_IDLE;
            lit_which = 2'd0;
            lit_index = 3'd0;
            position = 16'd0;
            token_start = 16'd0;
            magnitude = 32'd0;
            negative = 1'b0;
            digits_stopped = 1'b0;
            fraction_seen = 1'b0;
        endfunction

        function logic is_digit(logic [7:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function void add_token(logic [3:0] kind, logic [31:0] value, logic [15:0] lo,
                                logic [15:0] hi, logic [2:0] err);
            token_t t;
            t = '{kind, value, lo, hi, err, 1'b0};
            from_byte.push_back(t);
        endfunction

        function void add_punct(logic [3:0] kind);
            add_token(kind, 32'd0, 16'd0, 16'd0, ERR_NONE);
            position++;
        endfunction

        function void scan_idle(logic [7:0] c);
            case (c)
                CH_SPACE, CH_TAB, CH_LF: position++;
                CH_QUOTE:
                begin
                    mode = SCAN_STRING;
                    token_start = position + 16'd1;
                    position++;
                end
                CH_LBRACE: add_punct(KIND_LBRACE);
                CH_RBRACE: add_punct(KIND_RBRACE);
                CH_LBRACK: add_punct(KIND_LBRACK);
                CH_RBRACK: add_punct(KIND_RBRACK);
                CH_COLON:  add_punct(KIND_COLON);
                CH_COMMA:  add_punct(KIND_COMMA);
                CH_T, CH_F, CH_N:
                begin
                    mode = SCAN_LITERAL;
                    lit_which = (c == CH_T) ? 2'd0 : (c == CH_F) ? 2'd1 : 2'd2;
                    lit_index = 3'd0;
                    position++;
                end
                CH_NUL:
                begin
                    add_token(KIND_END, 32'd0, 16'd0, 16'd0, ERR_NONE);
                    clear_state();
                end
                default:
                begin
                    if (is_digit(c) || c == CH_MINUS)
                    begin
                        mode = SCAN_NUMBER;
                        token_start = position;
                        negative = (c == CH_MINUS);
                        magnitude = is_digit(c) ? 32'(c - CH_0) : 32'd0;
                        digits_stopped = 1'b0;
                        fraction_seen = 1'b0;
                        position++;
                    end
                    else
                    begin
                        add_token(KIND_ERROR, 32'd0, 16'd0, 16'd0, ERR_BAD_CHAR);
                        mode = SCAN_SKIP;
                    end
                end
            endcase
        endfunction

        function void note_byte(logic [7:0] c);
            logic [63:0] wide;
            logic [31:0] result;
            from_byte.delete();
            if (mode == SCAN_SKIP)
            begin
                if (c == CH_NUL)
                    clear_state();
            end
            else if (c != CH_NUL && position == POS_LIMIT)
            begin
                add_token(KIND_ERROR, 32'd0, 16'd0, 16'd0, ERR_TOO_LONG);
                mode = SCAN_SKIP;
            end
            else
            begin
                case (mode)
                    SCAN_NUMBER:
                    begin
                        if (is_digit(c))
                        begin
                            if (!digits_stopped)
                            begin
                                wide = 64'(magnitude) * 64'd10 + 64'(c - CH_0);
                                magnitude = (wide > 64'h8000_0000) ? 32'h8000_0000 : wide[31:0];
                            end
                            position++;
                        end
                        else if (c == CH_MINUS || c == CH_PLUS)
                        begin
                            digits_stopped = 1'b1;
                            position++;
                        end
                        else if (c == CH_E_LO || c == CH_E_UP || c == CH_DOT)
                        begin
                            digits_stopped = 1'b1;
                            fraction_seen = 1'b1;
                            position++;
                        end
                        else
                        begin
                            if (fraction_seen)
                                add_token(KIND_DOUBLE, 32'd0, token_start, position - 16'd1,
                                          ERR_NONE);
                            else
                            begin
                                if (negative)
                                    result = -magnitude;
                                else
                                    result = (magnitude > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                                         : magnitude;
                                add_token(KIND_INT, result, token_start, position - 16'd1,
                                          ERR_NONE);
                            end
                            mode = SCAN_IDLE;
                            scan_idle(c);
                        end
                    end
                    SCAN_STRING:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            add_token(KIND_STRING, 32'd0, token_start, position - 16'd1,
                                      ERR_NONE);
                            mode = SCAN_IDLE;
                            position++;
                        end
                        else if (c == CH_NUL)
                        begin
                            add_token(KIND_ERROR, 32'd0, 16'd0, 16'd0, ERR_UNTERMINATED);
                            clear_state();
                        end
                        else
                            position++;
                    end
                    SCAN_LITERAL:
                    begin
                        if (c == word_tail[lit_which].getc(lit_index))
                        begin
                            lit_index++;
                            position++;
                            if (lit_index == word_tail[lit_which].len())
                            begin
                                add_token(KIND_TRUE + 4'(lit_which), 32'd0, 16'd0, 16'd0,
                                          ERR_NONE);
                                mode = SCAN_IDLE;
                                lit_index = 3'd0;
                            end
                        end
                        else if (c == CH_NUL)
                        begin
                            add_token(KIND_ERROR, 32'd0, 16'd0, 16'd0, ERR_BAD_LITERAL);
                            clear_state();
                        end
                        else
                        begin
                            add_token(KIND_ERROR, 32'd0, 16'd0, 16'd0, ERR_BAD_LITERAL);
                            mode = SCAN_SKIP;
                        end
                    end
                    default:
                    begin
                        mode = SCAN_IDLE;
                        scan_idle(c);
                    end
                endcase
            end
            if (from_byte.size() > 0)
                from_byte[from_byte.size() - 1].last_of_run = 1'b1;
            foreach (from_byte[i])
                tokens_due.push_back(from_byte[i]);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
                $display("Mismatch on token %0d: %s", checked, what);
        endtask

        task check_token(token_t got);
            token_t want;
            checked++;
            if (tokens_due.size() == 0)
                report_mismatch($sformatf("kind %0d arrived with no token expected", got.kind));
            else
            begin
                want = tokens_due.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("token_kind %0d, expected %0d",
                                              got.kind, want.kind));
                if (got.value !== want.value)
                    report_mismatch($sformatf("int_value %0d, expected %0d",
                                              got.value, want.value));
                if (got.span_lo !== want.span_lo)
                    report_mismatch($sformatf("span_start %0d, expected %0d",
                                              got.span_lo, want.span_lo));
                if (got.span_hi !== want.span_hi)
                    report_mismatch($sformatf("span_end %0d, expected %0d",
                                              got.span_hi, want.span_hi));
                if (got.err !== want.err)
                    report_mismatch($sformatf("error_code %0d, expected %0d",
                                              got.err, want.err));
                if (got.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                              got.last_of_run, want.last_of_run));
            end
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic [7:0]         byte_in = 8'h00;
    logic               pop = 1'b0;
    logic               full;
    logic               empty;
    logic [3:0]         token_kind;
    logic signed [31:0] int_value;
    logic [15:0]        span_start;
    logic [15:0]        span_end;
    logic [2:0]         error_code;
    logic               last_of_run;

    logic         idle_on = 1'b1;
    logic [7:0]   doc_bytes[$];
    int           sent_count;
    int           cycle_count;
    string        punct_chars = "{}[]:,";
    string        fraction_marks = ".eE";
    string        literal_words[3] = '{"true", "false", "null"};
    string        extreme_numbers[5] = '{"-2147483648", "2147483647", "2147483648",
                                         "-2147483649", "000012345678901"};
    string        directed_docs[6] = '{"[-7,\"a\"]", "{true:1e}", "nul", "\"x", "fx1", "9"};
    token_checker board = new();

    json_token_scanner u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .byte_in     (byte_in),
        .empty       (empty),
        .pop         (pop),
        .token_kind  (token_kind),
        .int_value   (int_value),
        .span_start  (span_start),
        .span_end    (span_end),
        .error_code  (error_code),
        .last_of_run (last_of_run)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                board.note_byte(byte_in);
            if (pop && !empty)
                board.check_token('{token_kind, int_value, span_start, span_end, error_code,
                                    last_of_run});
        end
    end

    always
    begin
        @(posedge clk);
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        pop <= 1'b1;
    end

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_content();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_QUOTE);
        return b;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            doc_bytes.push_back(s[i]);
    endfunction

    function automatic void add_digits(int count);
        repeat (count)
            doc_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
    endfunction

    function automatic void add_number();
        int shape;
        shape = $urandom_range(0, 11);
        if (shape == 0)
            add_text(extreme_numbers[$urandom_range(0, 4)]);
        else if (shape == 1)
            doc_bytes.push_back(CH_MINUS);
        else
        begin
            if ($urandom_range(0, 2) == 0)
                doc_bytes.push_back(CH_MINUS);
            add_digits(($urandom_range(0, 4) == 0) ? $urandom_range(9, 13)
                                                   : $urandom_range(1, 4));
            if (shape >= 8)
            begin
                doc_bytes.push_back(fraction_marks[$urandom_range(0, 2)]);
                if ($urandom_range(0, 1) == 0)
                    doc_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
                add_digits($urandom_range(0, 3));
            end
            else if (shape == 7)
            begin
                doc_bytes.push_back(($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
                add_digits($urandom_range(1, 3));
            end
        end
    endfunction

    function automatic void add_string();
        doc_bytes.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6))
            doc_bytes.push_back(pick_content());
        doc_bytes.push_back(CH_QUOTE);
    endfunction

    // Returns 1 when the document is cut short and must end right here.
    function automatic logic add_noise();
        string word;
        logic  cut;
        word = literal_words[$urandom_range(0, 2)];
        cut = 1'b0;
        case ($urandom_range(0, 3))
            0: doc_bytes.push_back(8'($urandom_range(1, 255)));
            1:
            begin
                add_text(word.substr(0, $urandom_range(0, word.len() - 2)));
                doc_bytes.push_back(8'($urandom_range(1, 255)));
            end
            2:
            begin
                add_text(word.substr(0, $urandom_range(0, word.len() - 2)));
                cut = 1'b1;
            end
            default:
            begin
                doc_bytes.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 3))
                    doc_bytes.push_back(pick_content());
                cut = 1'b1;
            end
        endcase
        return cut;
    endfunction

    function automatic void build_document(logic noisy);
        int   count;
        logic cut;
        doc_bytes.delete();
        count = $urandom_range(1, 12);
        cut = 1'b0;
        for (int i = 0; i < count && !cut; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                doc_bytes.push_back(pick_blank());
            if (noisy && $urandom_range(0, count - 1) == 0)
                cut = add_noise();
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: add_number();
                    3, 4:    add_string();
                    5:       add_text(literal_words[$urandom_range(0, 2)]);
                    default: doc_bytes.push_back(punct_chars[$urandom_range(0, 5)]);
                endcase
            end
        end
        doc_bytes.push_back(CH_NUL);
    endfunction

    task automatic send_byte(input logic [7:0] value);
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        push <= 1'b1;
        byte_in <= value;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_document();
        foreach (doc_bytes[i])
            send_byte(doc_bytes[i]);
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_docs[i])
        begin
            doc_bytes.delete();
            add_text(directed_docs[i]);
            doc_bytes.push_back(CH_NUL);
            send_document();
        end
        doc_bytes = '{8'hFF, CH_NUL};
        send_document();

        sent_count = 0;
        while (sent_count < RANDOM_BYTES)
        begin
            idle_on = (sent_count < RANDOM_BYTES - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            build_document($urandom_range(0, 4) == 0);
            sent_count += doc_bytes.size();
            send_document();
        end

        push <= 1'b0;
        while (board.tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
